// ===== hdl/nps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_pkg - nearest palette color search shared definitions
// word layouts, register indexes, reset values and small helpers
// ----------------------------------------------------------------------------
package nps_pkg;

   // palette geometry
   localparam int PALETTE_DEPTH = 256;
   localparam int IDX_W         = $clog2(PALETTE_DEPTH);

   // field widths
   localparam int CHAN_W = 16;
   localparam int PIX_W  = 24;
   localparam int CNT_W  = 9;
   localparam int SQ_W   = 2 * CHAN_W;
   localparam int DIST_W = SQ_W + 2;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_MASK    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_MASK  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_MASK   = 3'd4;

   localparam logic             COLOR_MODE_RST  = 1'b0;
   localparam logic [CNT_W-1:0] ENTRY_COUNT_RST = 9'd256;
   localparam logic [PIX_W-1:0] RED_MASK_RST    = 24'hFF0000;
   localparam logic [PIX_W-1:0] GREEN_MASK_RST  = 24'h00FF00;
   localparam logic [PIX_W-1:0] BLUE_MASK_RST   = 24'h0000FF;

   // item kinds and color modes
   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_QUERY   = 1'b1;
   localparam logic COLOR_INDEXED = 1'b0;
   localparam logic COLOR_TRUE    = 1'b1;

   // input word
   typedef struct packed {
      logic              mode;
      logic [7:0]        entry_index;
      logic [CHAN_W-1:0] entry_red;
      logic [CHAN_W-1:0] entry_green;
      logic [CHAN_W-1:0] entry_blue;
      logic [PIX_W-1:0]  entry_pixel;
      logic              entry_excluded;
      logic [CHAN_W-1:0] target_red;
      logic [CHAN_W-1:0] target_green;
      logic [CHAN_W-1:0] target_blue;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [PIX_W-1:0]  match_pixel;
      logic [CHAN_W-1:0] match_red;
      logic [CHAN_W-1:0] match_green;
      logic [CHAN_W-1:0] match_blue;
      logic              found;
   } rsp_word_type;

   // one palette row
   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [PIX_W-1:0]  pixel;
      logic              excluded;
   } entry_type;

   function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
      absdiff = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

// ===== hdl/nearest_palette_color_search_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_search_core - palette store and nearest color search
// loads palette rows and answers nearest color queries over the palette
// ----------------------------------------------------------------------------
//
//   channel | ports                               | direction | moves
//   --------+-------------------------------------+-----------+-------------------
//   req     | req_valid, req_stall, req_data      | in        | load or query word
//   rsp     | rsp_valid, rsp_stall, rsp_data      | out       | match word
//   csr     | csr_valid, csr_ready, csr_index/wdata | in      | register write
//
// a load word writes one palette row
// a query scans the palette rows in order: one shared 16x16
// multiplier squares one channel difference per cycle, three per row
// req_stall is high from a query's accept until its result is moved into the
// output register; a waiting result does not hold off the next word
// synchronous reset clears control and registers; palette rows are undefined
// until loaded
//
module nearest_palette_color_search_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  nps_pkg::req_word_type                 req_data,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output nps_pkg::rsp_word_type                 rsp_data,
   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [nps_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [nps_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FILL  = 4'd1;   // first row read in flight
   localparam logic [3:0] S_SCAN  = 4'd2;   // three phases per row
   localparam logic [3:0] S_DRAIN = 4'd3;   // compare of the last row
   localparam logic [3:0] S_RD0   = 4'd4;   // fetch of the chosen rows
   localparam logic [3:0] S_RD1   = 4'd5;
   localparam logic [3:0] S_RD2   = 4'd6;
   localparam logic [3:0] S_RD3   = 4'd7;
   localparam logic [3:0] S_RD4   = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   // scan phases, one channel each
   localparam logic [1:0] PH_RED   = 2'd0;
   localparam logic [1:0] PH_GREEN = 2'd1;
   localparam logic [1:0] PH_BLUE  = 2'd2;

   localparam int IDX_W  = nps_pkg::IDX_W;
   localparam int CHAN_W = nps_pkg::CHAN_W;
   localparam int PIX_W  = nps_pkg::PIX_W;
   localparam int SQ_W   = nps_pkg::SQ_W;
   localparam int DIST_W = nps_pkg::DIST_W;

   // palette memory, one row per entry, registered read
   nps_pkg::entry_type mem [nps_pkg::PALETTE_DEPTH];
   nps_pkg::entry_type mem_q_ff;
   logic [IDX_W-1:0]   addr_ff;

   // configuration registers
   logic                        color_mode_ff;
   logic [nps_pkg::CNT_W-1:0]   entry_count_ff;
   logic [PIX_W-1:0]            red_mask_ff;
   logic [PIX_W-1:0]            green_mask_ff;
   logic [PIX_W-1:0]            blue_mask_ff;

   // sequencer
   logic [3:0] state_ff, state_in;
   logic [1:0] ph_ff, ph_in;

   // scan datapath
   nps_pkg::req_word_type tgt_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  last_ff;
   logic [IDX_W-1:0]  cand_ff;
   logic [SQ_W-1:0]   sq_ff;
   logic [DIST_W-1:0] acc_ff;
   logic [DIST_W-1:0] best_ff;
   logic              excl_cur_ff;
   logic              excl_pend_ff;
   logic              pend_ff;
   logic              have_ff;
   logic [CHAN_W-1:0] best_r_ff, best_g_ff, best_b_ff;
   logic [IDX_W-1:0]  pick_r_ff, pick_g_ff, pick_b_ff;

   // result assembly
   nps_pkg::rsp_word_type res_ff;
   nps_pkg::rsp_word_type rsp_data_ff;
   logic                  rsp_valid_ff;

   // handshake decode
   logic req_take;
   logic query_take;
   logic load_take;
   logic out_free;
   logic csr_take;

   // arithmetic
   logic [CHAN_W-1:0] ad_r, ad_g, ad_b;
   logic [CHAN_W-1:0] mul_a;
   logic [SQ_W-1:0]   sq_in;
   logic [DIST_W-1:0] row_dist;
   logic              cmp_go;
   logic              better;
   logic              found;
   logic [IDX_W-1:0]  scan_last;
   logic [PIX_W-1:0]  mask_r, mask_g, mask_b;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign query_take = req_take && (req_data.mode == nps_pkg::MODE_QUERY);
   assign load_take  = req_take && (req_data.mode == nps_pkg::MODE_LOAD);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;
   assign csr_take   = csr_valid && csr_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // last scanned row, entry count clamped to 1..depth
   always_comb begin
      priority if (entry_count_ff == '0) begin
         scan_last = '0;
      end else if (32'(entry_count_ff) > nps_pkg::PALETTE_DEPTH) begin
         scan_last = IDX_W'(nps_pkg::PALETTE_DEPTH - 1);
      end else begin
         scan_last = IDX_W'(entry_count_ff - 9'd1);
      end
   end

   // per-channel distances of the row on the read port
   assign ad_r = nps_pkg::absdiff(tgt_ff.target_red,   mem_q_ff.red);
   assign ad_g = nps_pkg::absdiff(tgt_ff.target_green, mem_q_ff.green);
   assign ad_b = nps_pkg::absdiff(tgt_ff.target_blue,  mem_q_ff.blue);

   // shared squarer, one channel per phase
   always_comb begin
      unique case (ph_ff)
         PH_RED:   mul_a = ad_r;
         PH_GREEN: mul_a = ad_g;
         PH_BLUE:  mul_a = ad_b;
         default:  mul_a = ad_r;
      endcase
   end
   assign sq_in = {{CHAN_W{1'b0}}, mul_a} * {{CHAN_W{1'b0}}, mul_a};

   // indexed compare of the pending row, overlapped with the next row's red
   assign row_dist = acc_ff + DIST_W'(sq_ff);
   assign cmp_go   = (color_mode_ff == nps_pkg::COLOR_INDEXED) &&
                     (((state_ff == S_SCAN) && (ph_ff == PH_RED) && pend_ff) ||
                      (state_ff == S_DRAIN));
   assign better   = !excl_pend_ff && (!have_ff || (row_dist < best_ff));

   assign found = (color_mode_ff == nps_pkg::COLOR_TRUE) || have_ff;

   // indexed mode takes the whole pixel from its one match
   always_comb begin
      if (color_mode_ff == nps_pkg::COLOR_TRUE) begin
         mask_r = red_mask_ff;
         mask_g = green_mask_ff;
         mask_b = blue_mask_ff;
      end else begin
         mask_r = '1;
         mask_g = '0;
         mask_b = '0;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      ph_in    = ph_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (query_take) begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            state_in = S_SCAN;
            ph_in    = PH_RED;
         end
         S_SCAN: begin
            unique case (ph_ff)
               PH_RED:   ph_in = PH_GREEN;
               PH_GREEN: ph_in = PH_BLUE;
               PH_BLUE: begin
                  ph_in = PH_RED;
                  if (idx_ff == last_ff) begin
                     state_in = S_DRAIN;
                  end
               end
               default:  ph_in = PH_RED;
            endcase
         end
         S_DRAIN: state_in = S_RD0;
         S_RD0:   state_in = S_RD1;
         S_RD1:   state_in = S_RD2;
         S_RD2:   state_in = S_RD3;
         S_RD3:   state_in = S_RD4;
         S_RD4:   state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         ph_ff          <= PH_RED;
         rsp_valid_ff   <= 1'b0;
         pend_ff        <= 1'b0;
         have_ff        <= 1'b0;
         color_mode_ff  <= nps_pkg::COLOR_MODE_RST;
         entry_count_ff <= nps_pkg::ENTRY_COUNT_RST;
         red_mask_ff    <= nps_pkg::RED_MASK_RST;
         green_mask_ff  <= nps_pkg::GREEN_MASK_RST;
         blue_mask_ff   <= nps_pkg::BLUE_MASK_RST;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;

         // result register: load on finish, drop on take
         if ((state_ff == S_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (query_take) begin
            pend_ff <= 1'b0;
            have_ff <= 1'b0;
         end else begin
            if ((state_ff == S_SCAN) && (ph_ff == PH_BLUE)) begin
               pend_ff <= 1'b1;
            end
            if (cmp_go && better) begin
               have_ff <= 1'b1;
            end
         end

         if (csr_take) begin
            unique case (csr_index)
               nps_pkg::CSR_COLOR_MODE:  color_mode_ff  <= csr_wdata[0];
               nps_pkg::CSR_ENTRY_COUNT: entry_count_ff <= csr_wdata[nps_pkg::CNT_W-1:0];
               nps_pkg::CSR_RED_MASK:    red_mask_ff    <= csr_wdata[PIX_W-1:0];
               nps_pkg::CSR_GREEN_MASK:  green_mask_ff  <= csr_wdata[PIX_W-1:0];
               nps_pkg::CSR_BLUE_MASK:   blue_mask_ff   <= csr_wdata[PIX_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // palette write port, slots beyond the depth are dropped
   always_ff @(posedge clock) begin
      if (load_take && (32'(req_data.entry_index) < nps_pkg::PALETTE_DEPTH)) begin
         mem[IDX_W'(req_data.entry_index)] <= '{red:      req_data.entry_red,
                                                green:    req_data.entry_green,
                                                blue:     req_data.entry_blue,
                                                pixel:    req_data.entry_pixel,
                                                excluded: req_data.entry_excluded};
      end
   end

   // palette read port
   always_ff @(posedge clock) begin
      mem_q_ff <= mem[addr_ff];
   end

   // scan and assembly datapath
   always_ff @(posedge clock) begin
      if (query_take) begin
         tgt_ff  <= req_data;
         last_ff <= scan_last;
         addr_ff <= '0;
         idx_ff  <= '0;
      end

      if (state_ff == S_SCAN) begin
         sq_ff <= sq_in;
         unique case (ph_ff)
            PH_RED: begin
               excl_cur_ff <= mem_q_ff.excluded;
               // per-channel search, strict compare keeps the first row
               if (color_mode_ff == nps_pkg::COLOR_TRUE) begin
                  if ((idx_ff == '0) || (ad_r < best_r_ff)) begin
                     best_r_ff <= ad_r;
                     pick_r_ff <= idx_ff;
                  end
                  if ((idx_ff == '0) || (ad_g < best_g_ff)) begin
                     best_g_ff <= ad_g;
                     pick_g_ff <= idx_ff;
                  end
                  if ((idx_ff == '0) || (ad_b < best_b_ff)) begin
                     best_b_ff <= ad_b;
                     pick_b_ff <= idx_ff;
                  end
               end
            end
            PH_GREEN: begin
               acc_ff  <= DIST_W'(sq_ff);
               // next row lands on the read port by the next red phase
               addr_ff <= idx_ff + IDX_W'(1);
            end
            PH_BLUE: begin
               acc_ff       <= acc_ff + DIST_W'(sq_ff);
               cand_ff      <= idx_ff;
               excl_pend_ff <= excl_cur_ff;
               if (idx_ff != last_ff) begin
                  idx_ff <= idx_ff + IDX_W'(1);
               end
            end
            default: ;
         endcase
      end

      if (cmp_go && better) begin
         best_ff   <= row_dist;
         pick_r_ff <= cand_ff;
         pick_g_ff <= cand_ff;
         pick_b_ff <= cand_ff;
      end

      // fetch the chosen rows, read data passes through the address and read registers
      unique case (state_ff)
         S_RD0: addr_ff <= pick_r_ff;
         S_RD1: addr_ff <= pick_g_ff;
         S_RD2: begin
            addr_ff           <= pick_b_ff;
            res_ff.match_red   <= mem_q_ff.red;
            res_ff.match_pixel <= mem_q_ff.pixel & mask_r;
         end
         S_RD3: begin
            res_ff.match_green <= mem_q_ff.green;
            res_ff.match_pixel <= res_ff.match_pixel | (mem_q_ff.pixel & mask_g);
         end
         S_RD4: begin
            res_ff.match_blue  <= mem_q_ff.blue;
            res_ff.match_pixel <= res_ff.match_pixel | (mem_q_ff.pixel & mask_b);
            res_ff.found       <= found;
         end
         default: ;
      endcase

      // in indexed mode, all rows excluded gives an empty word
      if ((state_ff == S_DONE) && out_free) begin
         if (res_ff.found) begin
            rsp_data_ff <= res_ff;
         end else begin
            rsp_data_ff <= '0;
         end
      end
   end

endmodule

// ===== hdl/nps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_checker - port level checks for the nearest palette color search
// watches the request and response ports over time
// ----------------------------------------------------------------------------
module nps_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input nps_pkg::req_word_type          req_data,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input nps_pkg::rsp_word_type          rsp_data,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [nps_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [nps_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // a waiting result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // a query occupies the block on the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.mode == nps_pkg::MODE_QUERY) |=> req_stall)
      else $error("query accepted but block not busy");

   // a load word never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.mode == nps_pkg::MODE_LOAD) && !rsp_valid
      |=> !rsp_valid)
      else $error("result word after a palette load");

   // no match means an all-zero word
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |->
         (rsp_data.match_pixel == '0) && (rsp_data.match_red == '0) &&
         (rsp_data.match_green == '0) && (rsp_data.match_blue == '0))
      else $error("empty result carries data");

   // reset leaves no result pending and the block idle
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind nearest_palette_color_search_core nps_checker u_nps_checker (.*);
